### rtl/perspective_point_projection_core_defines.svh
`ifndef PERSPECTIVE_POINT_PROJECTION_CORE_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PPP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppp: check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define PPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppp: check failed");

`endif

### rtl/ppp_pkg.sv
package ppp_pkg;

  // input item: world point, signed Q8.8
  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [15:0]        inv_distance;
    logic               out_of_range;
  } out_item_t;

  // camera registers
  typedef struct packed {
    logic signed [15:0] cam_pos_x;
    logic signed [15:0] cam_pos_y;
    logic signed [15:0] cam_pos_z;
    logic signed [15:0] sin_pitch;
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_yaw;
    logic [15:0]        focal_length;
  } cfg_t;

  // register indexes
  localparam logic [2:0] CFG_CAM_POS_X    = 3'd0;
  localparam logic [2:0] CFG_CAM_POS_Y    = 3'd1;
  localparam logic [2:0] CFG_CAM_POS_Z    = 3'd2;
  localparam logic [2:0] CFG_SIN_PITCH    = 3'd3;
  localparam logic [2:0] CFG_COS_PITCH    = 3'd4;
  localparam logic [2:0] CFG_SIN_YAW      = 3'd5;
  localparam logic [2:0] CFG_COS_YAW      = 3'd6;
  localparam logic [2:0] CFG_FOCAL_LENGTH = 3'd7;

  localparam logic signed [15:0] TRIG_ONE     = 16'sh4000;
  localparam logic [15:0]        FOCAL_RESET  = 16'd618;

  // saturation values
  localparam logic [15:0] SAT_POS  = 16'h7FFF;
  localparam logic [15:0] SAT_NEG  = 16'h8000;
  localparam logic [15:0] INV_MAX  = 16'hFFFF;

  // squared distances at or below this give a reciprocal of 65536 or more
  localparam logic [34:0] DIST_SAT_MAX = 35'd65536;

  // front pipeline depth
  localparam int FRONT_STAGES = 6;
  localparam int FRONT_CNT_W  = $clog2(FRONT_STAGES + 1);

  // classified item handed from front to back
  typedef struct packed {
    logic [63:0] prod_x;    // |dx| * focal
    logic        neg_x;
    logic        sat_x;
    logic [15:0] spec_x;    // value used when saturated
    logic [63:0] prod_y;
    logic        neg_y;
    logic        sat_y;
    logic [15:0] spec_y;
    logic [47:0] den;       // positive depth
    logic [34:0] dist_sq;
    logic        dist_sat;
    logic        oor;
  } q_entry_t;

endpackage

### rtl/ppp_front.sv
module ppp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               take_i,
  input  ppp_pkg::in_item_t                  item_i,
  input  ppp_pkg::cfg_t                      cfg_i,
  output logic                               push_o,
  output ppp_pkg::q_entry_t                  entry_o,
  output logic [ppp_pkg::FRONT_CNT_W-1:0]    busy_o
);
  import ppp_pkg::*;

  logic [FRONT_STAGES-1:0] vld_q, vld_d;

  // stage 1: relative position
  logic signed [16:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  // stage 2: products
  logic signed [32:0] cypz_d, sypx_d, cypx_d, sypz_d, cxpy_d, sxpy_d;
  logic signed [32:0] cypz_q, sypx_q, cypx_q, sypz_q, cxpy_q, sxpy_q;
  logic [32:0]        sqx_d, sqy_d, sqz_d, sqx_q, sqy_q, sqz_q;
  // stage 3: yaw sums
  logic signed [33:0] t_d, xr_d, t_q, xr_q;
  logic signed [32:0] cxpy3_q, sxpy3_q;
  logic [34:0]        ssq_d, ssq3_q;
  // stage 4: pitch products
  logic signed [49:0] sxt_d, cxt_d, sxt_q, cxt_q;
  logic signed [33:0] xr4_q;
  logic signed [32:0] cxpy4_q, sxpy4_q;
  logic [34:0]        ssq4_q;
  // stage 5: view vector, magnitudes
  logic signed [47:0] dx;
  logic signed [50:0] dy, dz_d, dz5_q;
  logic [47:0]        magx_d, magy_d, magx_q, magy_q;
  logic               negx5_q, negy5_q;
  logic [34:0]        ssq5_q;
  // stage 6: focal products
  logic [63:0]        prodx_d, prody_d, prodx_q, prody_q;
  logic signed [50:0] dz6_q;
  logic               negx6_q, negy6_q;
  logic [34:0]        ssq6_q;
  // classification
  logic               dz_pos, sat_x, sat_y, dist_sat;
  logic [63:0]        lim;

  // valid shift line, front never stalls
  assign vld_d = {vld_q[FRONT_STAGES-2:0], take_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign busy_o = FRONT_CNT_W'($countones(vld_q));
  assign push_o = vld_q[FRONT_STAGES-1];

  // datapath arithmetic
  always_comb begin
    px_d = $signed({item_i.point_x[15], item_i.point_x})
         - $signed({cfg_i.cam_pos_x[15], cfg_i.cam_pos_x});
    py_d = $signed({item_i.point_y[15], item_i.point_y})
         - $signed({cfg_i.cam_pos_y[15], cfg_i.cam_pos_y});
    pz_d = $signed({item_i.point_z[15], item_i.point_z})
         - $signed({cfg_i.cam_pos_z[15], cfg_i.cam_pos_z});

    cypz_d = 33'(cfg_i.cos_yaw) * 33'(pz_q);
    sypx_d = 33'(cfg_i.sin_yaw) * 33'(px_q);
    cypx_d = 33'(cfg_i.cos_yaw) * 33'(px_q);
    sypz_d = 33'(cfg_i.sin_yaw) * 33'(pz_q);
    cxpy_d = 33'(cfg_i.cos_pitch) * 33'(py_q);
    sxpy_d = 33'(cfg_i.sin_pitch) * 33'(py_q);
    sqx_d  = 33'(px_q) * 33'(px_q);
    sqy_d  = 33'(py_q) * 33'(py_q);
    sqz_d  = 33'(pz_q) * 33'(pz_q);

    t_d   = 34'(cypz_q) + 34'(sypx_q);
    xr_d  = 34'(cypx_q) - 34'(sypz_q);
    ssq_d = 35'(sqx_q) + 35'(sqy_q) + 35'(sqz_q);

    sxt_d = 50'(cfg_i.sin_pitch) * 50'(t_q);
    cxt_d = 50'(cfg_i.cos_pitch) * 50'(t_q);

    dx     = 48'(xr4_q) <<< 14;
    dy     = 51'(sxt_q) + (51'(cxpy4_q) <<< 14);
    dz_d   = 51'(cxt_q) - (51'(sxpy4_q) <<< 14);
    magx_d = dx[47] ? 48'(-dx) : 48'(dx);
    magy_d = dy[50] ? 48'(-dy) : 48'(dy);

    prodx_d = 64'(magx_q) * 64'(cfg_i.focal_length);
    prody_d = 64'(magy_q) * 64'(cfg_i.focal_length);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    pz_q    <= pz_d;
    cypz_q  <= cypz_d;
    sypx_q  <= sypx_d;
    cypx_q  <= cypx_d;
    sypz_q  <= sypz_d;
    cxpy_q  <= cxpy_d;
    sxpy_q  <= sxpy_d;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    sqz_q   <= sqz_d;
    t_q     <= t_d;
    xr_q    <= xr_d;
    cxpy3_q <= cxpy_q;
    sxpy3_q <= sxpy_q;
    ssq3_q  <= ssq_d;
    sxt_q   <= sxt_d;
    cxt_q   <= cxt_d;
    xr4_q   <= xr_q;
    cxpy4_q <= cxpy3_q;
    sxpy4_q <= sxpy3_q;
    ssq4_q  <= ssq3_q;
    magx_q  <= magx_d;
    magy_q  <= magy_d;
    negx5_q <= dx[47];
    negy5_q <= dy[50];
    dz5_q   <= dz_d;
    ssq5_q  <= ssq4_q;
    prodx_q <= prodx_d;
    prody_q <= prody_d;
    negx6_q <= negx5_q;
    negy6_q <= negy5_q;
    dz6_q   <= dz5_q;
    ssq6_q  <= ssq5_q;
  end

  // classify: depth sign, screen overflow, distance saturation
  always_comb begin
    dz_pos   = !dz6_q[50] && (dz6_q != '0);
    lim      = {1'b0, dz6_q[47:0], 15'b0};
    sat_x    = !dz_pos || (prodx_q >= lim);
    sat_y    = !dz_pos || (prody_q >= lim);
    dist_sat = ssq6_q <= DIST_SAT_MAX;

    entry_o.prod_x   = prodx_q;
    entry_o.neg_x    = negx6_q;
    entry_o.sat_x    = sat_x;
    entry_o.spec_x   = (!dz_pos && prodx_q == '0) ? '0 : (negx6_q ? SAT_NEG : SAT_POS);
    entry_o.prod_y   = prody_q;
    entry_o.neg_y    = negy6_q;
    entry_o.sat_y    = sat_y;
    entry_o.spec_y   = (!dz_pos && prody_q == '0) ? '0 : (negy6_q ? SAT_NEG : SAT_POS);
    entry_o.den      = dz6_q[47:0];
    entry_o.dist_sq  = ssq6_q;
    entry_o.dist_sat = dist_sat;
    entry_o.oor      = sat_x || sat_y || dist_sat;
  end

endmodule

### rtl/ppp_queue.sv
module ppp_queue #(
  parameter int Depth = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ppp_pkg::q_entry_t           entry_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output ppp_pkg::q_entry_t           entry_o,
  output logic [$clog2(Depth+1)-1:0]  cnt_o
);
  import ppp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];
  assign cnt_o   = cnt_q;

endmodule

### rtl/ppp_back.sv
module ppp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ppp_pkg::q_entry_t   q_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ppp_pkg::out_item_t  out_item_o
);
  import ppp_pkg::*;

  localparam int SCR_STEPS  = 15;  // quotient bits of a screen coordinate
  localparam int DIV_STEPS  = 32;  // quotient bits of 2^48 / dist_sq
  localparam int SQRT_STEPS = 16;  // root digits
  localparam int NB         = DIV_STEPS + SQRT_STEPS;
  localparam logic [35:0] DIV_INIT = 36'd65536;

  typedef struct packed {
    q_entry_t               e;      // prod_x / prod_y hold the remainders
    logic [SCR_STEPS-1:0]   qx;
    logic [SCR_STEPS-1:0]   qy;
    logic [35:0]            drem;
    logic [31:0]            dquo;   // quotient, then shifted out two bits a root step
    logic [19:0]            srem;
    logic [15:0]            sroot;
  } bk_t;

  bk_t         stg_q [NB+1];
  bk_t         nx    [NB+1];
  logic [NB:0] vld_q;
  logic        en;
  bk_t         last;
  logic [15:0] qx_w, qy_w;

  // whole back pipeline moves unless the result is held
  assign en    = !vld_q[NB] || out_ready_i;
  assign pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NB-1:0], q_valid_i};
    end
  end

  // one restoring division step or one root digit per stage
  always_comb begin
    logic [63:0] dsh;
    logic [35:0] r2;
    logic [19:0] rn;
    logic [19:0] trial;
    dsh   = '0;
    r2    = '0;
    rn    = '0;
    trial = '0;
    nx[0]      = '0;
    nx[0].e    = q_entry_i;
    nx[0].drem = DIV_INIT;
    for (int k = 1; k <= NB; k++) begin
      nx[k] = stg_q[k-1];
      // screen quotient bits, most significant first
      if (k <= SCR_STEPS) begin
        dsh = 64'(stg_q[k-1].e.den) << (SCR_STEPS - k);
        if (stg_q[k-1].e.prod_x >= dsh) begin
          nx[k].e.prod_x = stg_q[k-1].e.prod_x - dsh;
          nx[k].qx       = {stg_q[k-1].qx[SCR_STEPS-2:0], 1'b1};
        end else begin
          nx[k].qx       = {stg_q[k-1].qx[SCR_STEPS-2:0], 1'b0};
        end
        if (stg_q[k-1].e.prod_y >= dsh) begin
          nx[k].e.prod_y = stg_q[k-1].e.prod_y - dsh;
          nx[k].qy       = {stg_q[k-1].qy[SCR_STEPS-2:0], 1'b1};
        end else begin
          nx[k].qy       = {stg_q[k-1].qy[SCR_STEPS-2:0], 1'b0};
        end
      end
      if (k <= DIV_STEPS) begin
        // reciprocal of squared distance
        r2 = {stg_q[k-1].drem[34:0], 1'b0};
        if (r2 >= 36'(stg_q[k-1].e.dist_sq)) begin
          nx[k].drem = r2 - 36'(stg_q[k-1].e.dist_sq);
          nx[k].dquo = {stg_q[k-1].dquo[30:0], 1'b1};
        end else begin
          nx[k].drem = r2;
          nx[k].dquo = {stg_q[k-1].dquo[30:0], 1'b0};
        end
      end else begin
        // square root of the quotient, two bits a step
        rn    = {stg_q[k-1].srem[17:0], stg_q[k-1].dquo[31:30]};
        trial = {2'b00, stg_q[k-1].sroot, 2'b01};
        nx[k].dquo = {stg_q[k-1].dquo[29:0], 2'b00};
        if (rn >= trial) begin
          nx[k].srem  = rn - trial;
          nx[k].sroot = {stg_q[k-1].sroot[14:0], 1'b1};
        end else begin
          nx[k].srem  = rn;
          nx[k].sroot = {stg_q[k-1].sroot[14:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= NB; k++) begin
        stg_q[k] <= nx[k];
      end
    end
  end

  // result formatting
  always_comb begin
    last = stg_q[NB];
    qx_w = {1'b0, last.qx};
    qy_w = {1'b0, last.qy};
    out_item_o.screen_x     = last.e.sat_x ? last.e.spec_x
                            : (last.e.neg_x ? 16'(16'd0 - qx_w) : qx_w);
    out_item_o.screen_y     = last.e.sat_y ? last.e.spec_y
                            : (last.e.neg_y ? 16'(16'd0 - qy_w) : qy_w);
    out_item_o.inv_distance = last.e.dist_sat ? INV_MAX : last.sroot;
    out_item_o.out_of_range = last.e.oor;
  end

  assign out_valid_o = vld_q[NB];

endmodule

### rtl/perspective_point_projection_core.sv
// Perspective projection of one point per item: camera offset, yaw and pitch
// rotation, division by depth times focal length, and the reciprocal camera
// distance. A new item can be accepted every cycle while input ready is high;
// each item passes through the 6 front stages, the queue and the back pipeline.
// The back pipeline spends one stage per quotient bit of the 32-bit
// distance reciprocal and one per digit of its 16-bit square root; the 15
// screen quotient bits run in the first stages alongside. Input ready drops
// only when the queue cannot hold every item already in the front pipeline
// plus one more. Camera registers may be written only while no item is in
// flight.
`include "perspective_point_projection_core_defines.svh"

module perspective_point_projection_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ppp_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ppp_pkg::out_item_t  out_item_o
);
  import ppp_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW = ((CntW > FRONT_CNT_W) ? CntW : FRONT_CNT_W) + 1;

  cfg_t                   cfg_q;
  logic                   take;
  logic                   push;
  q_entry_t               push_entry;
  q_entry_t               head_entry;
  logic                   q_valid;
  logic                   q_pop;
  logic [CntW-1:0]        q_cnt;
  logic [FRONT_CNT_W-1:0] front_cnt;
  logic [SumW-1:0]        in_flight;

  // camera registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_pos_x    <= '0;
      cfg_q.cam_pos_y    <= '0;
      cfg_q.cam_pos_z    <= '0;
      cfg_q.sin_pitch    <= '0;
      cfg_q.cos_pitch    <= TRIG_ONE;
      cfg_q.sin_yaw      <= '0;
      cfg_q.cos_yaw      <= TRIG_ONE;
      cfg_q.focal_length <= FOCAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAM_POS_X:    cfg_q.cam_pos_x    <= cfg_wdata_i;
        CFG_CAM_POS_Y:    cfg_q.cam_pos_y    <= cfg_wdata_i;
        CFG_CAM_POS_Z:    cfg_q.cam_pos_z    <= cfg_wdata_i;
        CFG_SIN_PITCH:    cfg_q.sin_pitch    <= cfg_wdata_i;
        CFG_COS_PITCH:    cfg_q.cos_pitch    <= cfg_wdata_i;
        CFG_SIN_YAW:      cfg_q.sin_yaw      <= cfg_wdata_i;
        CFG_COS_YAW:      cfg_q.cos_yaw      <= cfg_wdata_i;
        CFG_FOCAL_LENGTH: cfg_q.focal_length <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // credit check: queue room for every item in the front plus the new one
  assign in_flight  = SumW'(front_cnt) + SumW'(q_cnt);
  assign in_ready_o = in_flight < SumW'(QUEUE_DEPTH);
  assign take       = in_valid_i && in_ready_o;

  ppp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .push_o  (push),
    .entry_o (push_entry),
    .busy_o  (front_cnt)
  );

  ppp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .cnt_o   (q_cnt)
  );

  ppp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // checks
  `PPP_ASSERT_SAME(a_credit_bound, 1'b1, in_flight <= SumW'(QUEUE_DEPTH))
  `PPP_ASSERT_SAME(a_pop_nonempty, q_pop, q_valid)
  `PPP_ASSERT_NEXT(a_take_enters_front, take, front_cnt != '0)

endmodule

### sim/tb_perspective_point_projection_core.sv
`timescale 1ns / 100ps

module tb_perspective_point_projection_core;
  import ppp_pkg::*;

  // camera shadow and expected projections
  class projection_scoreboard;
    cfg_t      cam;
    out_item_t projections_due[$];
    int        mismatches;

    function new();
      cam = '0;
      cam.cos_pitch    = TRIG_ONE;
      cam.cos_yaw      = TRIG_ONE;
      cam.focal_length = FOCAL_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_CAM_POS_X:    cam.cam_pos_x    = val;
        CFG_CAM_POS_Y:    cam.cam_pos_y    = val;
        CFG_CAM_POS_Z:    cam.cam_pos_z    = val;
        CFG_SIN_PITCH:    cam.sin_pitch    = val;
        CFG_COS_PITCH:    cam.cos_pitch    = val;
        CFG_SIN_YAW:      cam.sin_yaw      = val;
        CFG_COS_YAW:      cam.cos_yaw      = val;
        CFG_FOCAL_LENGTH: cam.focal_length = val;
        default: ;
      endcase
    endfunction

    // bitwise integer square root, floor
    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // focal * num / den with saturation, Q8.8
    function logic [15:0] screen_coord(longint num, longint den, inout bit flag);
      bit neg;
      longint unsigned mag, prod, d, q;
      neg  = num < 0;
      mag  = neg ? longint'(-num) : longint'(num);
      prod = mag * longint'({48'd0, cam.focal_length});
      if (den <= 0) begin
        flag = 1'b1;
        if (prod == 0) return 16'd0;
        return neg ? SAT_NEG : SAT_POS;
      end
      d = den;
      if (prod >= (d << 15)) begin
        flag = 1'b1;
        return neg ? SAT_NEG : SAT_POS;
      end
      q = prod / d;
      return neg ? 16'(-q) : q[15:0];
    endfunction

    function out_item_t project(in_item_t p);
      longint px, py, pz, t, dx, dy, dz, sx, cx, sy, cy;
      longint unsigned dist_sq, inv;
      bit flag;
      out_item_t r;
      px = longint'(p.point_x) - longint'(cam.cam_pos_x);
      py = longint'(p.point_y) - longint'(cam.cam_pos_y);
      pz = longint'(p.point_z) - longint'(cam.cam_pos_z);
      sx = longint'(cam.sin_pitch);
      cx = longint'(cam.cos_pitch);
      sy = longint'(cam.sin_yaw);
      cy = longint'(cam.cos_yaw);
      // yaw then pitch rotation
      t  = cy * pz + sy * px;
      dx = (cy * px - sy * pz) * 16384;
      dy = sx * t + cx * py * 16384;
      dz = cx * t - sx * py * 16384;
      dist_sq = px * px + py * py + pz * pz;
      flag = 1'b0;
      r.screen_x = screen_coord(dx, dz, flag);
      r.screen_y = screen_coord(dy, dz, flag);
      // reciprocal distance
      if (dist_sq == 0) begin
        inv = 64'(INV_MAX);
        flag = 1'b1;
      end else begin
        inv = int_sqrt((64'd1 << 48) / dist_sq);
        if (inv > INV_MAX) begin
          inv = 64'(INV_MAX);
          flag = 1'b1;
        end
      end
      r.inv_distance = inv[15:0];
      r.out_of_range = flag;
      return r;
    endfunction

    function void note_point(in_item_t p);
      projections_due.push_back(project(p));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (projections_due.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        mismatches++;
        return;
      end
      exp_r = projections_due.pop_front();
      if (got.screen_x !== exp_r.screen_x) begin
        $display("%0t: screen_x exp %0d got %0d", $time, exp_r.screen_x, got.screen_x);
        mismatches++;
      end
      if (got.screen_y !== exp_r.screen_y) begin
        $display("%0t: screen_y exp %0d got %0d", $time, exp_r.screen_y, got.screen_y);
        mismatches++;
      end
      if (got.inv_distance !== exp_r.inv_distance) begin
        $display("%0t: inv_distance exp %0d got %0d", $time,
                 exp_r.inv_distance, got.inv_distance);
        mismatches++;
      end
      if (got.out_of_range !== exp_r.out_of_range) begin
        $display("%0t: out_of_range exp %0b got %0b", $time,
                 exp_r.out_of_range, got.out_of_range);
        mismatches++;
      end
    endfunction
  endclass

  localparam int DRAIN_CYCLES = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;

  projection_scoreboard sb;
  int burst_left;

  perspective_point_projection_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // receiver stall pattern: modes held for random stretches
  initial begin
    int mode;
    int stretch;
    out_ready_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      stretch = $urandom_range(5, 120);
      repeat (stretch) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= ($urandom_range(0, 5) == 0);
          default: out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // wait until all projections are out, then let the pipeline settle
  task automatic wait_drained();
    while (sb.projections_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // drop valid when a burst is cut short
  task automatic idle_sender();
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_camera(cfg_t c);
    idle_sender();
    wait_drained();
    write_reg(CFG_CAM_POS_X, c.cam_pos_x);
    write_reg(CFG_CAM_POS_Y, c.cam_pos_y);
    write_reg(CFG_CAM_POS_Z, c.cam_pos_z);
    write_reg(CFG_SIN_PITCH, c.sin_pitch);
    write_reg(CFG_COS_PITCH, c.cos_pitch);
    write_reg(CFG_SIN_YAW, c.sin_yaw);
    write_reg(CFG_COS_YAW, c.cos_yaw);
    write_reg(CFG_FOCAL_LENGTH, c.focal_length);
  endtask

  // one item, with bursts and gaps on the sender side
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_item_t p;
    int gap;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_point(p);
    @(negedge clk_i);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  // random point: near the camera, in front of it, or anywhere
  task automatic send_random_point();
    logic [15:0] x, y, z;
    int spread;
    case ($urandom_range(0, 3))
      0: begin
        x = 16'($urandom);
        y = 16'($urandom);
        z = 16'($urandom);
      end
      1: begin
        spread = $urandom_range(0, 1) ? 300 : 8;
        x = 16'(sb.cam.cam_pos_x + $urandom_range(0, 2 * spread) - spread);
        y = 16'(sb.cam.cam_pos_y + $urandom_range(0, 2 * spread) - spread);
        z = 16'(sb.cam.cam_pos_z + $urandom_range(0, 2 * spread) - spread);
      end
      default: begin
        x = 16'(sb.cam.cam_pos_x + $urandom_range(0, 8000) - 4000);
        y = 16'(sb.cam.cam_pos_y + $urandom_range(0, 8000) - 4000);
        z = 16'(sb.cam.cam_pos_z + $urandom_range(256, 12000));
      end
    endcase
    send_point(x, y, z);
  endtask

  function automatic logic [15:0] random_trig();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // timeout
  initial begin
    #4000000;
    $display("tb_perspective_point_projection_core: done, errors");
    $finish;
  end

  // main stimulus
  initial begin
    cfg_t c;
    sb = new();
    burst_left = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_CAM_POS_X;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset camera: zero distance, behind, tiny distance, extremes
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'd0, 16'd0, 16'd256);
    send_point(16'd100, -16'sd50, -16'sd256);
    send_point(16'd1, 16'd0, 16'd0);
    send_point(16'd3, 16'd2, 16'd1);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h8000, 16'd1);
    send_point(16'h8000, 16'h7FFF, 16'd2);
    send_point(16'd500, -16'sd700, 16'd1000);
    send_point(16'd0, 16'd0, -16'sd1);

    // extreme camera, steep pitch and yaw, largest focal length
    c.cam_pos_x = 16'h8000; c.cam_pos_y = 16'h7FFF; c.cam_pos_z = 16'h8000;
    c.sin_pitch = -16'sd16384; c.cos_pitch = 16'd0;
    c.sin_yaw = 16'sd16384; c.cos_yaw = 16'd0;
    c.focal_length = 16'hFFFF;
    write_camera(c);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);

    // trig outside the unit range, zero focal length
    c.cam_pos_x = 16'h7FFF; c.cam_pos_y = 16'h8000; c.cam_pos_z = 16'h7FFF;
    c.sin_pitch = 16'h7FFF; c.cos_pitch = 16'h8000;
    c.sin_yaw = 16'h8000; c.cos_yaw = 16'h7FFF;
    c.focal_length = 16'd0;
    write_camera(c);
    send_point(16'h8000, 16'h7FFF, 16'h8000);
    send_point(16'd0, 16'd0, 16'd0);
    send_point(16'h7FFF, 16'h8000, 16'h7FFF);
    send_point(16'h1234, 16'hFEDC, 16'h5555);

    // random phases with fresh camera settings
    for (int ph = 0; ph < 12; ph++) begin
      c.cam_pos_x = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 4000) - 2000);
      c.cam_pos_y = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 4000) - 2000);
      c.cam_pos_z = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 4000) - 2000);
      c.sin_pitch = random_trig();
      c.cos_pitch = random_trig();
      c.sin_yaw   = random_trig();
      c.cos_yaw   = random_trig();
      case ($urandom_range(0, 4))
        0: c.focal_length = 16'($urandom);
        1: c.focal_length = FOCAL_RESET;
        default: c.focal_length = 16'($urandom_range(64, 2048));
      endcase
      if (ph == 11) begin
        c = '0;
        c.cos_pitch = TRIG_ONE;
        c.cos_yaw = TRIG_ONE;
        c.focal_length = FOCAL_RESET;
      end
      write_camera(c);
      for (int n = 0; n < 150; n++) begin
        // hold off once mid-phase until every projection is back
        if (ph == 3 && n == 75) begin
          idle_sender();
          while (sb.projections_due.size() != 0) @(posedge clk_i);
        end
        send_random_point();
      end
    end

    idle_sender();
    wait_drained();
    if (sb.mismatches == 0 && sb.projections_due.size() == 0) begin
      $display("tb_perspective_point_projection_core: done, clean");
    end else begin
      $display("tb_perspective_point_projection_core: done, errors");
    end
    $finish;
  end

endmodule
